// ----- hw/rtl/ecm_pkg.sv -----
package ecm_pkg;

   localparam logic [1:0] CMD_TRACE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;
   localparam int MIX_SHIFT_A = 16;
   localparam int MIX_SHIFT_B = 15;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] location;
      logic [15:0] read_index;
   } ecm_item_type;

   typedef struct packed {
      logic         empty;
      ecm_item_type head;
   } ecm_queue_stat_type;

endpackage

// ----- hw/rtl/ecm_front.sv -----
module ecm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           req_cmd,
   input  logic [31:0]          req_frame_hash,
   input  logic [31:0]          req_opcode_index,
   input  logic                 req_exc_flag,
   input  logic [15:0]          req_read_index,
   input  logic                 clearing,
   input  logic                 q_full,
   output logic                 q_push,
   output ecm_pkg::ecm_item_type q_item
);
   import ecm_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic [1:0]  s1_cmd_ff, s2_cmd_ff;
   logic [31:0] s1_hash_ff, s2_hash_ff;
   logic [15:0] s1_ridx_ff, s2_ridx_ff;
   logic [31:0] s1_mix_ff, s1_mix_in;
   logic [31:0] s2_mix_ff, s2_mix_in;
   logic [31:0] seed;
   logic [31:0] fold_a;
   logic [31:0] fold_b;
   logic        advance;
   logic        accept;

   assign advance = !s2_valid_ff || !q_full;
   assign full    = clearing || !advance;
   assign accept  = push && !full;

   assign seed      = req_opcode_index ^ {31'd0, req_exc_flag};
   assign fold_a    = seed ^ (seed >> MIX_SHIFT_A);
   assign s1_mix_in = fold_a * MIX_MUL_A;
   assign fold_b    = s1_mix_ff ^ (s1_mix_ff >> MIX_SHIFT_B);
   assign s2_mix_in = fold_b * MIX_MUL_B;

   assign s1_valid_in = advance ? accept : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff  <= req_cmd;
         s1_hash_ff <= req_frame_hash;
         s1_ridx_ff <= req_read_index;
         s1_mix_ff  <= s1_mix_in;
         s2_cmd_ff  <= s1_cmd_ff;
         s2_hash_ff <= s1_hash_ff;
         s2_ridx_ff <= s1_ridx_ff;
         s2_mix_ff  <= s2_mix_in;
      end
   end

   assign q_push              = s2_valid_ff && !q_full;
   assign q_item.cmd          = s2_cmd_ff;
   assign q_item.location     = s2_hash_ff ^ s2_mix_ff ^ (s2_mix_ff >> MIX_SHIFT_A);
   assign q_item.read_index   = s2_ridx_ff;

endmodule

// ----- hw/rtl/ecm_queue.sv -----
module ecm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_push,
   input  ecm_pkg::ecm_item_type      q_item,
   output logic                       q_full,
   input  logic                       q_pop,
   output ecm_pkg::ecm_queue_stat_type q_stat
);
   import ecm_pkg::*;

   ecm_item_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign q_full  = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && (count_ff != '0);

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_item;
      end
   end

   assign q_stat.empty = count_ff == '0;
   assign q_stat.head  = slot_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/ecm_back.sv -----
module ecm_back #(
   parameter int MAP_INDEX_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ecm_pkg::ecm_queue_stat_type q_stat,
   output logic                        q_pop,
   output logic                        clearing,
   output logic                        empty,
   input  logic                        pop,
   output logic [15:0]                 rsp_map_index,
   output logic [7:0]                  rsp_hit_count
);
   import ecm_pkg::*;

   localparam int IDX_W   = MAP_INDEX_BITS;
   localparam int ENTRIES = 1 << IDX_W;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       cmd_ff;
   logic [31:0]      loc_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_index_ff, rsp_index_in;
   logic [7:0]       rsp_count_ff, rsp_count_in;
   logic [7:0]       map_mem [ENTRIES];
   logic [7:0]       rd_data_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [31:0]      ridx_wide;
   logic [31:0]      idx_wide;
   logic             slot_free;
   logic             take;

   assign clearing  = state_ff == ST_CLEAR;
   assign slot_free = !rsp_valid_ff || pop;
   assign take      = (state_ff == ST_IDLE) && !q_stat.empty && slot_free;
   assign q_pop     = take;
   assign ridx_wide = 32'(q_stat.head.read_index);
   assign idx_wide  = 32'(idx_ff);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      prev_in      = prev_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data_ff + 8'd1;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = 8'd0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == {IDX_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               unique case (q_stat.head.cmd)
                  CMD_TRACE: begin
                     idx_in   = q_stat.head.location[IDX_W-1:0] ^ prev_ff;
                     state_in = ST_UPDATE;
                  end
                  CMD_READ: begin
                     idx_in   = ridx_wide[IDX_W-1:0];
                     state_in = ST_UPDATE;
                  end
                  CMD_START: begin
                     prev_in      = '0;
                     rsp_valid_in = 1'b1;
                     rsp_index_in = 16'd0;
                     rsp_count_in = 8'd0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = 16'd0;
                     rsp_count_in = 8'd0;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = idx_wide[15:0];
            state_in     = ST_IDLE;
            if (cmd_ff == CMD_TRACE) begin
               wr_en        = 1'b1;
               rsp_count_in = rd_data_ff + 8'd1;
               prev_in      = loc_ff[IDX_W:1];
            end else begin
               rsp_count_in = rd_data_ff;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      if (take) begin
         cmd_ff <= q_stat.head.cmd;
         loc_ff <= q_stat.head.location;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[idx_in];
   end

   assign empty         = !rsp_valid_ff;
   assign rsp_map_index = rsp_index_ff;
   assign rsp_hit_count = rsp_count_ff;

   a_no_take_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("queue popped during map clear");

   a_update_returns_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> state_ff == ST_IDLE)
      else $error("update did not return to idle");

   a_write_only_clear_or_update: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_UPDATE))
      else $error("map written outside clear or update");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !pop |=> rsp_valid_ff && $stable(rsp_index_ff) && $stable(rsp_count_ff))
      else $error("pending result lost or changed");

   a_take_needs_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> (!rsp_valid_ff || pop))
      else $error("update would overwrite pending result");

endmodule

// ----- hw/rtl/edge_coverage_map_update.sv -----
// Path: trace and read pass two hash stages, the queue and the registered map read
//   before the result reaches the ports; start-run and unused codes skip the map read.
// Back end: no new item is taken while a trace or read is in its update state, the
//   read-modify-write of the coverage map; other commands complete from idle.
// Reset: synchronous, active high; then a clearing pass writes zero to all
//   2^MAP_INDEX_BITS map entries while full stays high. Previous location resets to zero.
module edge_coverage_map_update #(
   parameter int MAP_INDEX_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_frame_hash,
   input  logic [31:0] req_opcode_index,
   input  logic        req_exc_flag,
   input  logic [15:0] req_read_index,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_map_index,
   output logic [7:0]  rsp_hit_count
);
   import ecm_pkg::*;

   ecm_item_type       q_item;
   ecm_queue_stat_type q_stat;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               clearing;

   ecm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_frame_hash   (req_frame_hash),
      .req_opcode_index (req_opcode_index),
      .req_exc_flag     (req_exc_flag),
      .req_read_index   (req_read_index),
      .clearing         (clearing),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_item)
   );

   ecm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_item (q_item),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_stat (q_stat)
   );

   ecm_back #(
      .MAP_INDEX_BITS (MAP_INDEX_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .clearing      (clearing),
      .empty         (empty),
      .pop           (pop),
      .rsp_map_index (rsp_map_index),
      .rsp_hit_count (rsp_hit_count)
   );

endmodule
